FILE: design/twa_pkg.sv
// Shared types and constants for the trailing window aggregate core.
// Used by the controller, the datapath and the top level; no dependencies.

package twa_pkg;

   localparam int SAMPLE_W    = 32;  // width of one sample
   localparam int AGG_W       = 38;  // width of the aggregate result
   localparam int MODE_W      = 2;
   localparam int WLEN_W      = 7;
   localparam int SUM_W       = SAMPLE_W + WLEN_W + 1;  // holds any windowed sum
   localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;
   localparam int RSP_DATA_W  = ((AGG_W + 7) / 8) * 8;

   // Aggregate kinds.
   localparam logic [MODE_W-1:0] MODE_AVG = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MIN = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SUM = 2'd3;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_MODE          = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH = 8'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the request and set up the walk
      logic walk;      // issue history reads and accumulate
      logic div_load;  // prime the divider with the sum
      logic div_step;  // one quotient bit
      logic finish;    // store the sample and load the result register
   } twa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;     // window holds no sample
      logic walk_done; // all reads issued and accumulated
      logic div_done;  // all quotient bits produced
      logic avg;       // average mode selected
      logic out_free;  // result register can take a new result
   } twa_sts_type;

endpackage

FILE: design/twa_ctrl.sv
// Controller state machine of the trailing window aggregate core.
// Depends on twa_pkg for the command and status structs.

module twa_ctrl import twa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  twa_sts_type sts,
   output twa_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_WALK = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.empty) begin
               state_in = ST_DONE;
            end else if (sts.walk_done) begin
               if (sts.avg) begin
                  cmd.div_load = 1'b1;
                  state_in     = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cmd.walk = 1'b1;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   // At most one command is active in any cycle.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("twa_ctrl: more than one command at once");

   // The divider is only stepped while it still has bits to produce.
   a_div_step: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !sts.div_done)
      else $error("twa_ctrl: divider stepped past its end");

   // A result is only loaded when the result register can take it.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.out_free)
      else $error("twa_ctrl: result loaded over a pending result");

endmodule

FILE: design/twa_datapath.sv
// Datapath of the trailing window aggregate core: configuration registers,
// history memory, accumulator, bit-serial divider and result register.
// Depends on twa_pkg; driven by twa_ctrl through command and status structs.

module twa_datapath import twa_pkg::*; #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic [SAMPLE_W-1:0]    req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  twa_cmd_type            cmd,
   output twa_sts_type            sts
);

   localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
   localparam int CALC_W  = ((SLOT_W > WLEN_W) ? SLOT_W : WLEN_W) + 2;
   localparam int CMP_W   = (COUNT_W > WLEN_W) ? COUNT_W : WLEN_W;

   // Configuration registers.
   logic [MODE_W-1:0] mode_ff;
   logic [WLEN_W-1:0] window_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_AVG;
         window_length_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == REG_MODE) begin
            mode_ff <= csr_data[MODE_W-1:0];
         end else if (csr_index == REG_WINDOW_LENGTH) begin
            window_length_ff <= csr_data[WLEN_W-1:0];
         end
      end
   end

   // Ring state.
   logic [SAMPLE_W-1:0] history_ff [MAX_WINDOW];
   logic [COUNT_W-1:0]  stored_count_ff;
   logic [SLOT_W-1:0]   write_slot_ff;

   // Per-request working registers.
   logic [SAMPLE_W-1:0] sample_ff;
   logic [WLEN_W-1:0]   n_ff;
   logic [WLEN_W-1:0]   issue_left_ff;
   logic [SLOT_W-1:0]   rd_slot_ff;
   logic                rd_pend_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SAMPLE_W-1:0] best_ff;
   logic                first_ff;

   // Divider registers.
   logic [SUM_W-1:0]     div_q_ff;
   logic [WLEN_W:0]      div_r_ff;
   logic                 div_neg_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   // Result register.
   logic               out_valid_ff;
   logic [AGG_W-1:0]   out_data_ff;

   // Window size and oldest slot, worked out when the request is taken.
   logic [CMP_W-1:0]  wl_ext;
   logic [CMP_W-1:0]  stored_ext;
   logic [WLEN_W-1:0] n_in;
   logic [CALC_W-1:0] ws_ext;
   logic [CALC_W-1:0] n_ext;
   logic [CALC_W-1:0] start_calc;
   logic [SLOT_W-1:0] start_slot;

   always_comb begin
      wl_ext     = CMP_W'(window_length_ff);
      stored_ext = CMP_W'(stored_count_ff);
      // When the history is the smaller of the two it is below 128.
      n_in       = (wl_ext < stored_ext) ? window_length_ff : stored_ext[WLEN_W-1:0];
      ws_ext     = CALC_W'(write_slot_ff);
      n_ext      = CALC_W'(n_in);
      if (ws_ext >= n_ext) begin
         start_calc = ws_ext - n_ext;
      end else begin
         start_calc = ws_ext + CALC_W'(MAX_WINDOW) - n_ext;
      end
      start_slot = start_calc[SLOT_W-1:0];
   end

   // Walk: one read issued per cycle, its data accumulated in the next.
   logic                       issue;
   logic signed [SAMPLE_W-1:0] rd_value;
   logic                       take_best;

   assign issue    = cmd.walk && (issue_left_ff != '0);
   assign rd_value = $signed(rd_data_ff);

   always_comb begin
      take_best = first_ff;
      if ((mode_ff == MODE_MAX) && (rd_value > best_ff)) begin
         take_best = 1'b1;
      end
      if ((mode_ff == MODE_MIN) && (rd_value < best_ff)) begin
         take_best = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= history_ff[rd_slot_ff];
      end
      if (cmd.finish) begin
         history_ff[write_slot_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff     <= req_tdata;
         n_ff          <= n_in;
         issue_left_ff <= n_in;
         rd_slot_ff    <= start_slot;
         sum_ff        <= '0;
         best_ff       <= '0;
         first_ff      <= 1'b1;
      end else begin
         if (issue) begin
            issue_left_ff <= issue_left_ff - 1'b1;
            if (rd_slot_ff == SLOT_W'(MAX_WINDOW - 1)) begin
               rd_slot_ff <= '0;
            end else begin
               rd_slot_ff <= rd_slot_ff + 1'b1;
            end
         end
         if (rd_pend_ff) begin
            sum_ff   <= sum_ff + SUM_W'(rd_value);
            first_ff <= 1'b0;
            if (take_best) begin
               best_ff <= rd_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= issue;
      end
   end

   // Restoring divider on the magnitude of the sum, one quotient bit a cycle.
   logic [WLEN_W:0] rem_shift;
   logic            rem_ge;

   assign rem_shift = {div_r_ff[WLEN_W-1:0], div_q_ff[SUM_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, n_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         div_neg_ff <= sum_ff[SUM_W-1];
         div_q_ff   <= sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         div_r_ff   <= '0;
      end else if (cmd.div_step) begin
         div_q_ff <= {div_q_ff[SUM_W-2:0], rem_ge};
         div_r_ff <= rem_ge ? (rem_shift - {1'b0, n_ff}) : rem_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_load) begin
         div_cnt_ff <= DIV_CNT_W'(SUM_W);
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   // Result selection.
   logic [SUM_W-1:0] quot_signed;
   logic [AGG_W-1:0] agg_in;

   always_comb begin
      quot_signed = div_neg_ff ? (~div_q_ff + 1'b1) : div_q_ff;
      agg_in      = '0;
      if (n_ff != '0) begin
         case (mode_ff)
            MODE_AVG: agg_in = quot_signed[AGG_W-1:0];
            MODE_SUM: agg_in = sum_ff[AGG_W-1:0];
            MODE_MAX, MODE_MIN: agg_in = AGG_W'(best_ff);
            default:  agg_in = '0;
         endcase
      end
   end

   // Ring update and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stored_count_ff <= '0;
         write_slot_ff   <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
            if (write_slot_ff == SLOT_W'(MAX_WINDOW - 1)) begin
               write_slot_ff <= '0;
            end else begin
               write_slot_ff <= write_slot_ff + 1'b1;
            end
            if (stored_count_ff < COUNT_W'(MAX_WINDOW)) begin
               stored_count_ff <= stored_count_ff + 1'b1;
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_data_ff <= agg_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_data_ff);

   assign sts.empty     = (n_ff == '0);
   assign sts.walk_done = (issue_left_ff == '0) && !rd_pend_ff;
   assign sts.div_done  = (div_cnt_ff == '0);
   assign sts.avg       = (mode_ff == MODE_AVG);
   assign sts.out_free  = !out_valid_ff || rsp_tready;

   // The held count never passes the ring depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      stored_count_ff <= COUNT_W'(MAX_WINDOW))
      else $error("twa_datapath: stored count beyond ring depth");

   // The window being walked never reaches past the samples held.
   a_window_held: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (CMP_W'(n_ff) <= CMP_W'(stored_count_ff)))
      else $error("twa_datapath: window longer than history");

   // Read data is only accumulated in the cycle after a read was issued.
   a_read_follow: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(issue))
      else $error("twa_datapath: accumulation without a read");

endmodule

FILE: design/trailing_window_aggregate_core.sv
// Top level of the trailing window aggregate core.
// Depends on twa_pkg, twa_ctrl and twa_datapath.
//
// Usage. Each request on the req_ channel carries one signed 32-bit sample.
// For every request the block returns one response on the rsp_ channel: the
// average, maximum, minimum or sum of the samples received before it, over
// at most window_length of them; the sample itself is stored afterwards.
// An empty window gives 0. The csr_ channel writes mode (index 0) and
// window_length (index 1); it is always ready and should be used only while
// no request is in flight.
// Timing. A request is taken in the idle state, then the history memory is
// read one sample a cycle over the n samples of the window; in average mode
// the bit-serial divider then divides the sum by n. The memory's single read
// port and the one-bit-per-cycle divider set how long a request takes.
// A finished response waits in an output register; the next request is
// accepted meanwhile, and its own response waits until that one is taken.
// Reset clears the configuration, the sample count and the ring pointer;
// the history memory is not cleared, as unwritten entries are never read.

module trailing_window_aggregate_core import twa_pkg::*; #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_W-1:0]    req_tdata,   // [31:0] sample (signed)
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [37:0] aggregate (signed), [39:38] zero
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   twa_cmd_type cmd;
   twa_sts_type sts;

   // Register writes are always taken: csr_ready is tied high.
   assign csr_ready = 1'b1;

   // The controller sequences load, walk, divide and finish for one request.
   twa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the history ring, the accumulator and the divider.
   twa_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

FILE: tb/tb_trailing_window_aggregate_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for trailing_window_aggregate_core.
// Holds its own windowed-aggregate predictor in a small class; depends only on
// twa_pkg and the core itself.

module tb_trailing_window_aggregate_core import twa_pkg::*; ();

   localparam int RING         = 64;         // history depth of the core
   localparam int RANDOM_ITEMS = 1700;       // requests in the random part
   localparam int TAIL_ITEMS   = 150;        // final stretch without idling
   localparam int DRAIN_CYCLES = 120;        // extra wait after the last aggregate returns
   localparam int LIMIT_CYCLES = 1_000_000;  // several times the slowest correct run

   // Predictor of the aggregate the core should return for each request,
   // together with the queue of aggregates still owed by the core.
   class trailing_aggregate_checker;
      logic [SAMPLE_W-1:0] history [RING];
      int unsigned         held;       // samples stored, saturating at RING
      int unsigned         next_slot;  // ring slot the next sample goes to
      logic [MODE_W-1:0]   kind;
      logic [WLEN_W-1:0]   span;
      logic [AGG_W-1:0]    expected_aggregates [$];
      int unsigned         errors;
      int unsigned         samples_noted;
      int unsigned         aggregates_checked;

      function new();
         held               = 0;
         next_slot          = 0;
         kind               = MODE_AVG;
         span               = '0;
         errors             = 0;
         samples_noted      = 0;
         aggregates_checked = 0;
      endfunction

      // Registers keep only their own width; other indexes are dropped.
      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         if (index == REG_MODE)
            kind = data[MODE_W-1:0];
         else if (index == REG_WINDOW_LENGTH)
            span = data[WLEN_W-1:0];
      endfunction

      // Works out the aggregate over the samples held before this one,
      // then stores the sample in the ring.
      function void note_sample(logic [SAMPLE_W-1:0] sample);
         int unsigned n;
         int unsigned slot;
         longint      total;
         longint      best;
         longint      value;
         longint      outcome;
         n       = (span < held) ? span : held;
         outcome = 0;
         if (n > 0) begin
            slot  = (next_slot + RING - n) % RING;
            total = 0;
            best  = longint'($signed(history[slot]));
            for (int k = 0; k < n; k++) begin
               value = longint'($signed(history[slot]));
               total += value;
               if (kind == MODE_MAX && value > best)
                  best = value;
               if (kind == MODE_MIN && value < best)
                  best = value;
               slot = (slot + 1) % RING;
            end
            case (kind)
               MODE_AVG: outcome = total / longint'(n);
               MODE_SUM: outcome = total;
               default:  outcome = best;
            endcase
         end
         expected_aggregates.push_back(outcome[AGG_W-1:0]);
         history[next_slot] = sample;
         next_slot = (next_slot + 1) % RING;
         if (held < RING)
            held++;
         samples_noted++;
      endfunction

      function void check_aggregate(logic [AGG_W-1:0] actual);
         logic [AGG_W-1:0] wanted;
         if (expected_aggregates.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected aggregate, expected none, actual %0d",
                     $time, $signed(actual));
            return;
         end
         wanted = expected_aggregates.pop_front();
         aggregates_checked++;
         if (actual !== wanted) begin
            errors++;
            $display("%0t ns: aggregate mismatch, expected %0d, actual %0d",
                     $time, $signed(wanted), $signed(actual));
         end
      endfunction

      function int unsigned pending();
         return expected_aggregates.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   trailing_aggregate_checker tracker;

   // When set, neither side inserts idle cycles: used for quiet stretches and
   // for the closing part of the run.
   logic        no_idle;
   int          rsp_stall_left;
   int unsigned cycle_count;
   int unsigned settings_applied;
   int unsigned random_sent;

   trailing_window_aggregate_core #(
      .MAX_WINDOW(RING)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // An 8 ns clock.
   always #4 clock = ~clock;

   // Everything the core sees is driven to a known value from time zero.
   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      no_idle    = 1'b0;
      rsp_stall_left = 0;
      cycle_count    = 0;
   end

   // Response side. The ready line changes on the falling edge; stalls come
   // in bursts of random length unless idling is switched off.
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every response taken at a rising edge is checked against the oldest
   // outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_aggregate(rsp_tdata[AGG_W-1:0]);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d aggregates outstanding",
                  cycle_count, tracker.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offers one request and waits for the core to take it. It is entered and
   // left at a falling edge with the valid line still high, so back-to-back
   // requests never lower and raise it within one step.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      req_tdata  <= sample;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker.note_sample(sample);
      @(negedge clock);
   endtask

   // Sender side idling: now and then a burst of empty cycles of random length.
   task automatic maybe_idle_sender();
      int gap;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Holds the request side off until every outstanding aggregate has been
   // returned, so the core is idle before its registers are touched.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One register write; leaves csr_valid high so that a following write in
   // the same burst does not toggle it within one step.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_index <= index;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(index, data);
      @(negedge clock);
   endtask

   // Drains the core, then writes both registers, optionally followed by a
   // write to an index that no register answers to.
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] mode_data,
                                input logic [CSR_DATA_W-1:0] length_data,
                                input bit stray_write);
      drain_responses();
      write_csr(REG_MODE, mode_data);
      write_csr(REG_WINDOW_LENGTH, length_data);
      if (stray_write)
         write_csr(CSR_INDEX_W'($urandom_range(REG_WINDOW_LENGTH + 1, 255)),
                   CSR_DATA_W'($urandom_range(0, 255)));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Random sample content. Flavour 0 is fully random, flavour 1 sits mostly
   // on one end of the range so that long windows reach the sum extremes,
   // flavour 2 stays near zero where averages truncate visibly.
   function automatic logic [SAMPLE_W-1:0] pick_sample(int flavour, bit high_pole);
      logic [SAMPLE_W-1:0] pole;
      pole = high_pole ? 32'h7FFF_FFFF : 32'h8000_0000;
      case (flavour)
         1:       return ($urandom_range(0, 9) != 0) ? pole : ~pole;
         2:       return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int          phase_len;
      int          flavour;
      int          choice;
      bit          high_pole;
      logic [WLEN_W-1:0]     length_pick;
      logic [CSR_DATA_W-1:0] mode_data;
      logic [CSR_DATA_W-1:0] length_data;

      tracker          = new();
      settings_applied = 0;
      random_sent      = 0;

      // Synchronous reset, held from time zero and released on a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Out of reset the window length is zero, so even the
      // extreme samples give an empty window and a zero aggregate.
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);

      // Sum with a window length above the ring depth: only the held samples
      // count, and the extremes of the sample range are mixed in.
      apply_setting({6'd0, MODE_SUM}, 8'd127, 1'b0);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h0000_0001);
      send_sample(32'h0000_0000);

      // Maximum, written with the unused upper bits of the data set, plus a
      // write to an index beyond the two registers, which must be ignored.
      apply_setting({6'h3F, MODE_MAX}, 8'd3, 1'b1);
      send_sample(-32'sd5);
      send_sample(-32'sd1);
      send_sample(-32'sd7);
      send_sample(32'd100);

      // Minimum over a single sample.
      apply_setting({6'd0, MODE_MIN}, 8'd1, 1'b0);
      send_sample(32'd5);
      send_sample(32'd3);

      // Average over two samples, with a negative sum that must truncate
      // toward zero; the window length byte also has its top bit set.
      apply_setting({6'd0, MODE_AVG}, 8'h82, 1'b0);
      send_sample(32'd4);
      send_sample(-32'sd7);
      send_sample(32'd0);

      // Random part: phases of random length, each under its own setting.
      // The ring fills within the first phases and then wraps for the rest
      // of the run. Every phase boundary drains the core first.
      while (random_sent < RANDOM_ITEMS) begin
         choice = $urandom_range(0, 9);
         if (choice == 0)
            length_pick = 7'd0;
         else if (choice <= 2)
            length_pick = 7'd64;
         else if (choice == 3)
            length_pick = WLEN_W'($urandom_range(65, 127));
         else
            length_pick = WLEN_W'($urandom_range(1, 64));
         mode_data   = {6'($urandom), 2'($urandom_range(0, 3))};
         length_data = {1'($urandom), length_pick};
         apply_setting(mode_data, length_data, $urandom_range(0, 5) == 0);

         flavour   = $urandom_range(0, 5);
         flavour   = (flavour >= 3) ? 0 : flavour;
         high_pole = 1'($urandom_range(0, 1));
         phase_len = $urandom_range(20, 120);
         if (phase_len > RANDOM_ITEMS - random_sent)
            phase_len = RANDOM_ITEMS - random_sent;

         // Some phases run without any idling; the closing stretch always does.
         no_idle = ($urandom_range(0, 4) == 0) ||
                   (random_sent + phase_len > RANDOM_ITEMS - TAIL_ITEMS);

         for (int i = 0; i < phase_len; i++) begin
            maybe_idle_sender();
            send_sample(pick_sample(flavour, high_pole));
            random_sent++;
         end
      end

      // Closing: wait for every outstanding aggregate, then a little longer
      // so that any spurious extra response would still be caught.
      no_idle = 1'b1;
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.pending() != 0) begin
         tracker.errors++;
         $display("%0t ns: %0d aggregates never returned", $time, tracker.pending());
      end

      $display("Sent %0d samples and checked %0d aggregates under %0d register settings,",
               tracker.samples_noted, tracker.aggregates_checked, settings_applied);
      $display("covering all four modes, empty and over-long windows and a wrapping ring.");
      if (tracker.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/twa_pkg.sv
design/twa_ctrl.sv
design/twa_datapath.sv
design/trailing_window_aggregate_core.sv
tb/tb_trailing_window_aggregate_core.sv
